// ----- hdl/fbpa_pkg.sv -----
`default_nettype none

package fbpa_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned OFF_W    = 22;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SIZE_W   = 17;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [SIZE_W-1:0]  SIZE_RESET     = 17'd64;
  localparam logic [SIZE_W-1:0]  MAX_BLOCK_SIZE = 17'd65536;
  localparam logic [COUNT_W-1:0] COUNT_RESET    = 7'd64;

  // register select is paddr bit 2 (registers at 0x0 and 0x4)
  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [SIZE_W-1:0]  block_size;
    logic [COUNT_W-1:0] block_count;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/fbpa_if.sv -----
`default_nettype none

interface fbpa_cmd_if import fbpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, command, block_index, input ready);
  modport sink   (input valid, command, block_index, output ready);
endinterface

interface fbpa_rsp_if import fbpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    granted_index;
  logic [OFF_W-1:0]    granted_offset;

  modport source (output valid, status, granted_index, granted_offset, input ready);
  modport sink   (input valid, status, granted_index, granted_offset, output ready);
endinterface

`default_nettype wire

// ----- hdl/fbpa_cfg.sv -----
`default_nettype none

module fbpa_cfg import fbpa_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel_i,
  input  wire logic               penable_i,
  input  wire logic               pwrite_i,
  input  wire logic [PADDR_W-1:0] paddr_i,
  input  wire logic [PDATA_W-1:0] pwdata_i,
  output logic      [PDATA_W-1:0] prdata_o,
  output cfg_t                    cfg_o
);

  logic [SIZE_W-1:0]  size_q, size_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               wr_en;

  assign wr_en = psel_i && penable_i && pwrite_i;

  always_comb begin
    size_d  = size_q;
    count_d = count_q;
    if (wr_en) begin
      unique case (paddr_i[2])
        REG_BLOCK_SIZE:  size_d  = pwdata_i[SIZE_W-1:0];
        REG_BLOCK_COUNT: count_d = pwdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_RESET;
      count_q <= COUNT_RESET;
    end else begin
      size_q  <= size_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    unique case (paddr_i[2])
      REG_BLOCK_SIZE:  prdata_o = PDATA_W'(size_q);
      REG_BLOCK_COUNT: prdata_o = PDATA_W'(count_q);
      default:         prdata_o = '0;
    endcase
  end

  assign cfg_o.block_size  = size_q;
  assign cfg_o.block_count = count_q;

endmodule

`default_nettype wire

// ----- hdl/fbpa_link_mem.sv -----
`default_nettype none

module fbpa_link_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 7
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fixed_block_pool_allocator_top.sv -----
// One item at a time: a command is taken only in idle. Allocate (link memory read
//   at the transfer), free (link write-back) and the unused command load their result
//   in the execute state once the result slot is free; init sweeps the link memory one
//   entry per cycle for N = min(block_count, MAX_BLOCKS) links; the last waits for the slot.
// Reset: asynchronous, active low; the free list comes up empty and the registers
//   at their defaults. The link memory is not cleared; init writes every link used.
`default_nettype none

module fixed_block_pool_allocator_top import fbpa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  fbpa_cmd_if.sink                cmd_i,
  fbpa_rsp_if.source              rsp_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int unsigned AW      = $clog2(MAX_BLOCKS);
  localparam int unsigned LW      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned MAX_SAT = (MAX_BLOCKS > 127) ? 127 : MAX_BLOCKS;
  localparam int unsigned CMP_W   = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
  localparam int unsigned PROD_W  = LW + SIZE_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_BLOCKS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_INIT = 2'd2;

  cfg_t cfg;

  fbpa_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign pready = 1'b1;

  logic [1:0]          state_q, state_d;
  cmd_e                cmd_q;
  logic [IDX_W-1:0]    idx_q;
  logic [LW-1:0]       head_q, head_d;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic [AW:0]         cnt_inc;
  logic                cnt_last;

  logic                rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0] rsp_status_q;
  logic [IDX_W-1:0]    rsp_gidx_q;
  logic [OFF_W-1:0]    rsp_goff_q;

  logic                res_load;
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_gidx;
  logic [OFF_W-1:0]    res_goff;

  logic                slot_free;
  logic                accept;
  logic                head_empty;
  logic [COUNT_W-1:0]  pool_n;
  logic [SIZE_W-1:0]   size_eff;
  logic [PROD_W-1:0]   prod;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [LW-1:0]       mem_wdata, mem_rdata;

  fbpa_link_mem #(
    .DEPTH (MAX_BLOCKS),
    .AW    (AW),
    .DW    (LW)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign pool_n   = (cfg.block_count > COUNT_W'(MAX_SAT)) ? COUNT_W'(MAX_SAT)
                                                          : cfg.block_count;
  assign size_eff = (cfg.block_size > MAX_BLOCK_SIZE) ? MAX_BLOCK_SIZE : cfg.block_size;

  assign head_empty = (head_q == NULL_LINK);
  assign slot_free  = !rsp_valid_q || rsp_o.ready;
  assign cmd_i.ready = (state_q == S_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;

  // head is read at the transfer so its link is ready in the execute cycle
  assign mem_re    = accept && (cmd_e'(cmd_i.command) == CMD_ALLOC) && !head_empty;
  assign mem_raddr = AW'(head_q);

  assign cnt_inc  = {1'b0, cnt_q} + 1'b1;
  assign cnt_last = (CMP_W'(cnt_inc) == CMP_W'(pool_n));
  assign prod     = PROD_W'(head_q) * PROD_W'(size_eff);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_gidx   = '0;
    res_goff   = '0;
    mem_we     = 1'b0;
    mem_waddr  = AW'(idx_q);
    mem_wdata  = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_q)
          CMD_INIT: begin
            if (pool_n == '0) begin
              if (slot_free) begin
                head_d   = NULL_LINK;
                res_load = 1'b1;
                state_d  = S_IDLE;
              end
            end else begin
              cnt_d   = '0;
              state_d = S_INIT;
            end
          end
          CMD_ALLOC: begin
            if (slot_free) begin
              res_load = 1'b1;
              state_d  = S_IDLE;
              if (head_empty) begin
                res_status = ST_EMPTY;
              end else begin
                head_d   = (mem_rdata > NULL_LINK) ? NULL_LINK : mem_rdata;
                res_gidx = IDX_W'(head_q);
                res_goff = OFF_W'(prod);
              end
            end
          end
          CMD_FREE: begin
            if (slot_free) begin
              res_load = 1'b1;
              state_d  = S_IDLE;
              if (COUNT_W'(idx_q) < pool_n) begin
                mem_we = 1'b1;
                head_d = LW'(idx_q);
              end else begin
                res_status = ST_BAD_INDEX;
              end
            end
          end
          CMD_NOP: begin
            if (slot_free) begin
              res_load = 1'b1;
              state_d  = S_IDLE;
            end
          end
          default: ;
        endcase
      end
      S_INIT: begin
        mem_waddr = cnt_q;
        mem_wdata = cnt_last ? NULL_LINK : LW'(cnt_inc);
        if (!cnt_last) begin
          mem_we = 1'b1;
          cnt_d  = cnt_inc[AW-1:0];
        end else if (slot_free) begin
          // last link waits here until the result slot opens
          mem_we   = 1'b1;
          head_d   = '0;
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (res_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NULL_LINK;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(cmd_i.command);
      idx_q <= cmd_i.block_index;
    end
    if (res_load) begin
      rsp_status_q <= res_status;
      rsp_gidx_q   <= res_gidx;
      rsp_goff_q   <= res_goff;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.granted_index  = rsp_gidx_q;
  assign rsp_o.granted_offset = rsp_goff_q;

endmodule

`default_nettype wire

// ----- hdl/fbpa_checker.sv -----
`default_nettype none

module fbpa_checker import fbpa_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire logic [STATUS_W-1:0] status_i,
  input wire logic [IDX_W-1:0]    gidx_i,
  input wire logic [OFF_W-1:0]    goff_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(status_i) && $stable(gidx_i) && $stable(goff_i))
    else $error("result changed while stalled");

  // a failed command (empty pool or bad index) grants nothing
  a_zero_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_EMPTY || status_i == ST_BAD_INDEX) |->
      gidx_i == '0 && goff_i == '0)
    else $error("grant fields set on a failed command");

  // one item in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken on two consecutive cycles");

  // checked at the following edge: the first edge under reset may still see power-up X
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_i.valid),
  .in_ready_i  (cmd_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .gidx_i      (rsp_o.granted_index),
  .goff_i      (rsp_o.granted_offset)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import fbpa_pkg::*;

  localparam int unsigned MAX_BLOCKS    = 64;
  localparam int unsigned LINK_W        = 7;
  localparam int unsigned SETTLE_CYCLES = 80;      // longest init sweep plus margin
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned MAX_REPORTS   = 10;

  localparam logic [LINK_W-1:0]  LINK_NIL   = LINK_W'(MAX_BLOCKS);
  localparam logic [PADDR_W-1:0] ADDR_SIZE  = {REG_BLOCK_SIZE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_COUNT = {REG_BLOCK_COUNT, 2'b00};

  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] idx;
  } pool_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    index;
    logic [OFF_W-1:0]    offset;
  } grant_t;

  typedef struct packed {
    logic [MAX_BLOCKS-1:0][LINK_W-1:0] link;
    logic [LINK_W-1:0]                 head;
    logic [SIZE_W-1:0]                 size;
    logic [COUNT_W-1:0]                count;
  } pool_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // DUT inputs come from these so they are known from time zero
  logic              cmd_valid   = 1'b0;
  cmd_e              cmd_code    = CMD_NOP;
  logic [IDX_W-1:0]  cmd_index   = '0;
  logic              rsp_ready   = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr      = '0;
  logic [PDATA_W-1:0] pwdata     = '0;
  logic [PDATA_W-1:0] prdata;
  logic              pready;

  fbpa_cmd_if cmd_if ();
  fbpa_rsp_if rsp_if ();

  assign cmd_if.valid       = cmd_valid;
  assign cmd_if.command     = cmd_code;
  assign cmd_if.block_index = cmd_index;
  assign rsp_if.ready       = rsp_ready;

  fixed_block_pool_allocator_top #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  pool_cmd_t       pending_q[$];
  grant_t          grant_q[$];
  logic [IDX_W-1:0] held_q[$];     // blocks the stimulus believes are allocated
  pool_t           model_pool;     // tracks the DUT at transfer time
  pool_t           gen_pool;       // tracks the stimulus as it is queued
  pool_cmd_t       drv_item;
  int unsigned     src_idle_pct  = 0;
  int unsigned     snk_stall_pct = 0;
  int unsigned     err_count     = 0;
  int unsigned     cycle_count   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic grant_t pool_apply(inout pool_t p, input cmd_e cmd,
                                        input logic [IDX_W-1:0] idx);
    grant_t      g;
    int unsigned n;
    int unsigned sz;
    int unsigned h;
    int unsigned i;
    g  = '0;
    g.status = ST_OK;
    n  = (p.count > MAX_BLOCKS) ? MAX_BLOCKS : p.count;
    sz = (p.size > MAX_BLOCK_SIZE) ? MAX_BLOCK_SIZE : p.size;
    case (cmd)
      CMD_INIT: begin
        for (i = 0; i < n; i++) p.link[i] = (i + 1 == n) ? LINK_NIL : LINK_W'(i + 1);
        p.head = (n == 0) ? LINK_NIL : '0;
      end
      CMD_ALLOC: begin
        if (p.head >= LINK_NIL) begin
          g.status = ST_EMPTY;
        end else begin
          h        = p.head;
          g.index  = IDX_W'(h);
          g.offset = OFF_W'(h * sz);
          p.head   = (p.link[h] > LINK_NIL) ? LINK_NIL : p.link[h];
        end
      end
      CMD_FREE: begin
        if (idx >= n) begin
          g.status = ST_BAD_INDEX;
        end else begin
          p.link[idx] = p.head;
          p.head      = LINK_W'(idx);
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  function automatic void check_grant(input grant_t got);
    grant_t want;
    if (grant_q.size() == 0) begin
      if (err_count < MAX_REPORTS)
        $display("unexpected grant: status %0d index %0d offset %0d",
                 got.status, got.index, got.offset);
      err_count++;
    end else begin
      want = grant_q.pop_front();
      if (got.status !== want.status || got.index !== want.index ||
          got.offset !== want.offset) begin
        if (err_count < MAX_REPORTS)
          $display("grant mismatch: exp status %0d index %0d offset %0d, got %0d %0d %0d",
                   want.status, want.index, want.offset,
                   got.status, got.index, got.offset);
        err_count++;
      end
    end
  endfunction

  // command driver; the model advances on each accepted transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_if.ready)
        grant_q.push_back(pool_apply(model_pool, cmd_code, cmd_index));
      if (!cmd_valid || cmd_if.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          drv_item  = pending_q.pop_front();
          cmd_valid <= 1'b1;
          cmd_code  <= drv_item.cmd;
          cmd_index <= drv_item.idx;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // grant monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_ready)
        check_grant(grant_t'{rsp_if.status, rsp_if.granted_index, rsp_if.granted_offset});
      rsp_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_item(input cmd_e cmd, input logic [IDX_W-1:0] idx);
    pool_cmd_t c;
    grant_t    g;
    int        k;
    c.cmd = cmd;
    c.idx = idx;
    pending_q.push_back(c);
    g = pool_apply(gen_pool, cmd, idx);
    if (cmd == CMD_INIT) begin
      held_q.delete();
    end else if (cmd == CMD_ALLOC && g.status == ST_OK) begin
      held_q.push_back(g.index);
    end else if (cmd == CMD_FREE && g.status == ST_OK) begin
      for (k = held_q.size() - 1; k >= 0; k--)
        if (held_q[k] == idx) held_q.delete(k);
    end
  endtask

  // mostly alloc/free of held blocks; some re-init, stray frees and unused commands
  task automatic queue_random(input int n);
    int               j;
    int unsigned      r;
    logic [IDX_W-1:0] idx_rand;
    for (j = 0; j < n; j++) begin
      r        = $urandom_range(99);
      idx_rand = IDX_W'($urandom);
      if (r < 4)
        queue_item(CMD_INIT, idx_rand);
      else if (r < 46 || (r < 86 && held_q.size() == 0))
        queue_item(CMD_ALLOC, idx_rand);
      else if (r < 86)
        queue_item(CMD_FREE, held_q[$urandom_range(held_q.size() - 1)]);
      else if (r < 94)
        queue_item(CMD_FREE, idx_rand);
      else
        queue_item(CMD_NOP, idx_rand);
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || cmd_valid || grant_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_config(input logic [SIZE_W-1:0] size, input logic [COUNT_W-1:0] count);
    logic [PDATA_W-1:0] data;
    // unused upper bits carry noise; the registers ignore them
    data = $urandom;
    data[SIZE_W-1:0] = size;
    apb_write(ADDR_SIZE, data);
    data = $urandom;
    data[COUNT_W-1:0] = count;
    apb_write(ADDR_COUNT, data);
    model_pool.size  = size;
    model_pool.count = count;
    gen_pool.size    = size;
    gen_pool.count   = count;
  endtask

  task automatic run_phase(input logic [SIZE_W-1:0] size, input logic [COUNT_W-1:0] count,
                           input int unsigned src_pct, input int unsigned snk_pct,
                           input int n);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_config(size, count);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    queue_item(CMD_INIT, IDX_W'($urandom));
    queue_random(n - 1);
  endtask

  initial begin
    model_pool.link  = '0;
    model_pool.head  = LINK_NIL;
    model_pool.size  = SIZE_RESET;
    model_pool.count = COUNT_RESET;
    gen_pool         = model_pool;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default registers: empty pool after reset, free before init, double free
    queue_item(CMD_ALLOC, 6'd63);
    queue_item(CMD_FREE,  6'd0);
    queue_item(CMD_ALLOC, 6'd0);
    queue_item(CMD_ALLOC, 6'd42);
    queue_item(CMD_FREE,  6'd63);
    queue_item(CMD_ALLOC, 6'd21);
    queue_item(CMD_NOP,   6'd63);
    queue_item(CMD_INIT,  6'd63);
    queue_item(CMD_ALLOC, 6'd0);
    queue_item(CMD_ALLOC, 6'd0);
    queue_item(CMD_ALLOC, 6'd0);
    queue_item(CMD_FREE,  6'd2);
    queue_item(CMD_FREE,  6'd1);
    queue_item(CMD_ALLOC, 6'd0);
    queue_item(CMD_FREE,  6'd63);
    queue_item(CMD_ALLOC, 6'd0);
    queue_item(CMD_ALLOC, 6'd0);
    queue_item(CMD_NOP,   6'd0);

    run_phase(17'd8,      7'd64,  0,  0,  150);
    run_phase(17'd65536,  7'd1,   60, 0,  100);
    run_phase(17'd131071, 7'd127, 0,  60, 150);
    run_phase(17'd7,      7'd0,   29, 29, 60);
    run_phase(17'd0,      7'd65,  0,  0,  100);
    run_phase(17'd4096,   7'd5,   60, 0,  130);
    run_phase(17'd48,     7'd32,  0,  60, 130);
    run_phase(SIZE_W'($urandom_range(65536, 8)), COUNT_W'($urandom_range(64, 1)),
              29, 29, 130);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
